[design/sdw_pkg.sv]
// Package for the segment decay weight block: fixed-point formats, pipeline
// sizes, register indexes and the constant tables of the CORDIC and exp units.
// No dependencies.
`default_nettype none

package sdw_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TRIG_STAGES     = 18;
    localparam int OUT_FRAC_BITS   = 16;

    localparam int ANGLE_W    = ANGLE_FRAC_BITS + 2;
    localparam int LEFF_W     = 32;
    localparam int COEFF_W    = 32;
    localparam int OUT_W      = OUT_FRAC_BITS + 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // CORDIC datapath, Q2.30 with headroom.
    localparam int CW = 34;
    localparam int PROD_W = COEFF_W + CW;

    // Quotient t = 2^62 / D is only kept below 32.0 in Q.24.
    localparam int T_W     = 29;
    localparam int D_W     = 64;
    localparam int N_W     = 6;
    localparam int R_W     = 30;
    localparam int TERM_W  = 31;
    localparam int SUM_W   = 33;
    localparam int SH_W    = 7;
    localparam int TAYLOR_TERMS = 14;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [ANGLE_W-1:0] PI_CODE =
        ANGLE_W'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
    localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [63:0] LN2_Q24 = 64'd11629080;
    localparam logic [D_W-1:0] D_LIMIT = D_W'(64'd1 << (62 - T_W));

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEFF_Z       = 3'd0,
        REG_COEFF_Y       = 3'd1,
        REG_ANGLE_MIN     = 3'd2,
        REG_ANGLE_MAX     = 3'd3,
        REG_FLY_NEGATIVE  = 3'd4,
        REG_SEGMENT_VALID = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic zero;
        logic ep;
        logic neg;
    } side_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Reciprocal multipliers m = ceil(2^(30+l)/k), l = ceil(log2 k); exact for
    // 30-bit dividends when followed by a right shift of 30+l.
    function automatic logic [31:0] taylor_mult(input int k);
        logic [31:0] m;
        case (k)
            1:  m = 32'd1073741824;
            2:  m = 32'd1073741824;
            3:  m = 32'd1431655766;
            4:  m = 32'd1073741824;
            5:  m = 32'd1717986919;
            6:  m = 32'd1431655766;
            7:  m = 32'd1227133514;
            8:  m = 32'd1073741824;
            9:  m = 32'd1908874354;
            10: m = 32'd1717986919;
            11: m = 32'd1561806290;
            12: m = 32'd1431655766;
            13: m = 32'd1321528399;
            14: m = 32'd1227133514;
            default: m = 32'd1073741824;
        endcase
        return m;
    endfunction

    function automatic int taylor_shift(input int k);
        int s;
        case (k)
            1:  s = 30;
            2:  s = 31;
            3:  s = 32;
            4:  s = 32;
            5:  s = 33;
            6:  s = 33;
            7:  s = 33;
            8:  s = 33;
            default: s = 34;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[design/segment_decay_weight.sv]
// Segment decay weight: fully pipelined CORDIC, product, divider and exp units.
// Depends on sdw_pkg.
//
// Usage: requests enter on in_valid/in_ready with emit_angle (Q2.16) and
// flight_length (Q16.16); each request gives exactly one contribution (Q1.16,
// signed) on out_valid/out_ready, in request order. Segment registers are
// written through cfg_we/cfg_addr/cfg_wdata while no request is in flight.
// The pipeline has one input stage, one CORDIC stage per iteration, two product
// stages, the divider set-up stage and one stage per quotient bit (29), two stages
// of ln2 reduction, two stages per Taylor term (multiply, then reciprocal
// multiply) and two output stages. Throughput is one request per cycle while
// the receiver accepts; every stage holds one request.
// Reset clears all valid bits and sets every segment register to zero, so the
// block answers zero until segment_valid is written. When the receiver stalls,
// the whole pipeline holds and in_ready drops in the same cycle; nothing is
// lost or repeated.
`default_nettype none

module segment_decay_weight (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sdw_pkg::ANGLE_W-1:0]          emit_angle,
    input  logic [sdw_pkg::LEFF_W-1:0]           flight_length,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sdw_pkg::OUT_W-1:0]     contribution,
    input  logic                                 cfg_we,
    input  logic [sdw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [sdw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import sdw_pkg::*;

    // Segment registers.
    logic signed [COEFF_W-1:0] coeff_z_reg, coeff_y_reg;
    logic [ANGLE_W-1:0]        angle_min_reg, angle_max_reg;
    logic                      fly_negative_reg, segment_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_z_reg       <= '0;
            coeff_y_reg       <= '0;
            angle_min_reg     <= '0;
            angle_max_reg     <= '0;
            fly_negative_reg  <= 1'b0;
            segment_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_COEFF_Z:       coeff_z_reg       <= $signed(cfg_wdata[COEFF_W-1:0]);
                REG_COEFF_Y:       coeff_y_reg       <= $signed(cfg_wdata[COEFF_W-1:0]);
                REG_ANGLE_MIN:     angle_min_reg     <= cfg_wdata[ANGLE_W-1:0];
                REG_ANGLE_MAX:     angle_max_reg     <= cfg_wdata[ANGLE_W-1:0];
                REG_FLY_NEGATIVE:  fly_negative_reg  <= cfg_wdata[0];
                REG_SEGMENT_VALID: segment_valid_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // One enable for the whole pipeline.
    logic adv;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] contribution_reg;

    assign adv          = !out_valid_reg || out_ready;
    assign in_ready     = adv;
    assign out_valid    = out_valid_reg;
    assign contribution = contribution_reg;

    // Input qualification.
    logic [ANGLE_W-1:0] span_lo, span_hi;
    side_t              in_side;

    always_comb
    begin
        span_lo = (angle_min_reg < angle_max_reg) ? angle_min_reg : angle_max_reg;
        span_hi = (angle_min_reg < angle_max_reg) ? angle_max_reg : angle_min_reg;
        in_side.zero = !segment_valid_reg || (emit_angle > PI_CODE) ||
                       (flight_length == '0) || (emit_angle < span_lo) ||
                       (emit_angle > span_hi);
        in_side.ep   = (emit_angle == angle_min_reg) || (emit_angle == angle_max_reg);
        in_side.neg  = fly_negative_reg;
    end

    // CORDIC stages.
    logic signed [CW-1:0] cx_reg [0:TRIG_STAGES];
    logic signed [CW-1:0] cy_reg [0:TRIG_STAGES];
    logic signed [CW-1:0] cz_reg [0:TRIG_STAGES];
    logic [LEFF_W-1:0]    cl_reg [0:TRIG_STAGES];
    side_t                cs_reg [0:TRIG_STAGES];
    logic [TRIG_STAGES:0] cv_reg;
    logic signed [CW-1:0] cx_next [0:TRIG_STAGES];
    logic signed [CW-1:0] cy_next [0:TRIG_STAGES];
    logic signed [CW-1:0] cz_next [0:TRIG_STAGES];

    always_comb
    begin
        cx_next[0] = '0;
        cy_next[0] = CORDIC_GAIN;
        cz_next[0] = $signed(CW'(emit_angle) << (30 - ANGLE_FRAC_BITS)) - HALF_PI_Q30;
        for (int i = 0; i < TRIG_STAGES; i++)
        begin
            if (cz_reg[i] >= 0)
            begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - atan_q30(i);
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + atan_q30(i);
            end
        end
    end

    // Products with the line coefficients, then |sum| truncated to Q.22.
    logic signed [PROD_W-1:0] m1_pz_reg, m1_py_reg;
    logic [LEFF_W-1:0]        m1_l_reg, m2_l_reg;
    side_t                    m1_s_reg, m2_s_reg;
    logic                     m1_v_reg, m2_v_reg;
    logic [31:0]              m2_p_reg;
    logic signed [PROD_W:0]   m2_sum;
    logic [PROD_W:0]          m2_abs;

    always_comb
    begin
        m2_sum = {m1_pz_reg[PROD_W-1], m1_pz_reg} + {m1_py_reg[PROD_W-1], m1_py_reg};
        m2_abs = (m2_sum < 0) ? $unsigned(-m2_sum) : $unsigned(m2_sum);
    end

    // Divider: stage 0 forms D; each later stage resolves one quotient bit.
    localparam int DS = T_W;
    logic [D_W-1:0] dr_reg [0:DS];
    logic [D_W-1:0] dd_reg [0:DS];
    logic [T_W-1:0] dq_reg [0:DS];
    side_t          ds_reg [0:DS];
    logic [DS:0]    dv_reg;
    logic [D_W-1:0] d0_next;
    side_t          ds0_next;
    logic [D_W-1:0] dr_next [1:DS];
    logic [T_W-1:0] dq_next [1:DS];
    logic [D_W:0]   d_twice;

    always_comb
    begin
        d0_next       = D_W'(m2_p_reg) * D_W'(m2_l_reg);
        ds0_next      = m2_s_reg;
        // A quotient of 32.0 or more, or a zero product, flushes to zero.
        ds0_next.zero = m2_s_reg.zero || (d0_next <= D_LIMIT);
        for (int j = 0; j < DS; j++)
        begin
            d_twice = {dr_reg[j], 1'b0};
            if (d_twice >= {1'b0, dd_reg[j]})
            begin
                dr_next[j+1] = D_W'(d_twice - {1'b0, dd_reg[j]});
                dq_next[j+1] = {dq_reg[j][T_W-2:0], 1'b1};
            end
            else
            begin
                dr_next[j+1] = D_W'(d_twice);
                dq_next[j+1] = {dq_reg[j][T_W-2:0], 1'b0};
            end
        end
    end

    // Range reduction t = n*ln2 + r, three quotient bits per stage.
    logic [T_W-1:0] n1_rem_reg, n1_rem_next, n2_rem_next;
    logic [2:0]     n1_n_reg, n1_n_next;
    logic [N_W-1:0] n2_n_reg;
    logic [2:0]     n2_lo_next;
    logic [R_W-1:0] n2_r_reg;
    side_t          n1_s_reg, n2_s_reg;
    logic           n1_v_reg, n2_v_reg;

    always_comb
    begin
        n1_rem_next = dq_reg[DS];
        for (int b = 5; b >= 3; b--)
        begin
            n1_n_next[b-3] = (n1_rem_next >= T_W'(LN2_Q24 << b));
            if (n1_n_next[b-3])
            begin
                n1_rem_next = n1_rem_next - T_W'(LN2_Q24 << b);
            end
        end
        n2_rem_next = n1_rem_reg;
        for (int b = 2; b >= 0; b--)
        begin
            n2_lo_next[b] = (n2_rem_next >= T_W'(LN2_Q24 << b));
            if (n2_lo_next[b])
            begin
                n2_rem_next = n2_rem_next - T_W'(LN2_Q24 << b);
            end
        end
    end

    // Taylor series for exp(-r): per term a product with r, then division
    // by k through a reciprocal multiply.
    localparam int TT = TAYLOR_TERMS;
    logic [2*TERM_W-2:0]    ta_p_reg [0:TT-1];
    logic signed [SUM_W-1:0] ta_s_reg [0:TT-1];
    logic [R_W-1:0]         ta_r_reg [0:TT-1];
    logic [N_W-1:0]         ta_n_reg [0:TT-1];
    side_t                  ta_d_reg [0:TT-1];
    logic [TT-1:0]          ta_v_reg;
    logic [R_W+31:0]        tb_p_reg [0:TT-1];
    logic signed [SUM_W-1:0] tb_s_reg [0:TT-1];
    logic [R_W-1:0]         tb_r_reg [0:TT-1];
    logic [N_W-1:0]         tb_n_reg [0:TT-1];
    side_t                  tb_d_reg [0:TT-1];
    logic [TT-1:0]          tb_v_reg;
    logic [2*TERM_W-2:0]    ta_p_next [0:TT-1];
    logic signed [SUM_W-1:0] ta_s_next [0:TT-1];
    logic [R_W+31:0]        tb_p_next [0:TT-1];
    logic [TERM_W-1:0]      t_term;

    always_comb
    begin
        t_term       = TERM_W'(64'd1 << 30);
        ta_s_next[0] = SUM_W'(64'd1 << 30);
        ta_p_next[0] = (2*TERM_W-1)'(t_term) * (2*TERM_W-1)'(n2_r_reg);
        for (int k = 1; k < TT; k++)
        begin
            t_term = TERM_W'(tb_p_reg[k-1] >> taylor_shift(k));
            if ((k % 2) == 1)
            begin
                ta_s_next[k] = tb_s_reg[k-1] - $signed({2'b00, t_term});
            end
            else
            begin
                ta_s_next[k] = tb_s_reg[k-1] + $signed({2'b00, t_term});
            end
            ta_p_next[k] = (2*TERM_W-1)'(t_term) * (2*TERM_W-1)'(tb_r_reg[k-1]);
        end
        for (int k = 0; k < TT; k++)
        begin
            tb_p_next[k] = (R_W+32)'(ta_p_reg[k][59:30]) * (R_W+32)'(taylor_mult(k+1));
        end
    end

    // Last term, clamp at zero.
    logic [TERM_W-1:0]       f1_e_reg, f1_e_next, f1_term;
    logic signed [SUM_W-1:0] f1_sum;
    logic [N_W-1:0]          f1_n_reg;
    side_t                   f1_s_reg;
    logic                    f1_v_reg;

    always_comb
    begin
        f1_term   = TERM_W'(tb_p_reg[TT-1] >> taylor_shift(TT));
        f1_sum    = tb_s_reg[TT-1] + $signed({2'b00, f1_term});
        f1_e_next = (f1_sum > 0) ? TERM_W'(f1_sum) : '0;
    end

    // Output scaling by 2^-n (one more at an endpoint), rounded half up.
    logic [SH_W-1:0]  f2_sh;
    logic [40:0]      f2_acc;
    logic [OUT_W-1:0] f2_mag;
    logic [OUT_W-1:0] contribution_next;

    always_comb
    begin
        f2_sh  = SH_W'(30 - OUT_FRAC_BITS) + SH_W'(f1_n_reg) + SH_W'(f1_s_reg.ep);
        f2_acc = 41'(f1_e_reg) + ((f2_sh == '0) ? 41'd0 : (41'd1 << (f2_sh - 1'b1)));
        f2_mag = OUT_W'(f2_acc >> f2_sh);
        if (f1_s_reg.zero || (f2_sh >= SH_W'(40)))
        begin
            f2_mag = '0;
        end
        contribution_next = f1_s_reg.neg ? OUT_W'(-f2_mag) : f2_mag;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg        <= '0;
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            dv_reg        <= '0;
            n1_v_reg      <= 1'b0;
            n2_v_reg      <= 1'b0;
            ta_v_reg      <= '0;
            tb_v_reg      <= '0;
            f1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg        <= {cv_reg[TRIG_STAGES-1:0], in_valid};
            m1_v_reg      <= cv_reg[TRIG_STAGES];
            m2_v_reg      <= m1_v_reg;
            dv_reg        <= {dv_reg[DS-1:0], m2_v_reg};
            n1_v_reg      <= dv_reg[DS];
            n2_v_reg      <= n1_v_reg;
            ta_v_reg[0]   <= n2_v_reg;
            tb_v_reg[0]   <= ta_v_reg[0];
            for (int k = 1; k < TT; k++)
            begin
                ta_v_reg[k] <= tb_v_reg[k-1];
                tb_v_reg[k] <= ta_v_reg[k];
            end
            f1_v_reg      <= tb_v_reg[TT-1];
            out_valid_reg <= f1_v_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= cx_next[0];
            cy_reg[0] <= cy_next[0];
            cz_reg[0] <= cz_next[0];
            cl_reg[0] <= flight_length;
            cs_reg[0] <= in_side;
            for (int i = 1; i <= TRIG_STAGES; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
                cl_reg[i] <= cl_reg[i-1];
                cs_reg[i] <= cs_reg[i-1];
            end

            m1_pz_reg <= coeff_z_reg * cx_reg[TRIG_STAGES];
            m1_py_reg <= coeff_y_reg * cy_reg[TRIG_STAGES];
            m1_l_reg  <= cl_reg[TRIG_STAGES];
            m1_s_reg  <= cs_reg[TRIG_STAGES];

            m2_p_reg <= m2_abs[63:32];
            m2_l_reg <= m1_l_reg;
            m2_s_reg <= m1_s_reg;

            dr_reg[0] <= D_LIMIT;
            dd_reg[0] <= d0_next;
            dq_reg[0] <= '0;
            ds_reg[0] <= ds0_next;
            for (int j = 1; j <= DS; j++)
            begin
                dr_reg[j] <= dr_next[j];
                dd_reg[j] <= dd_reg[j-1];
                dq_reg[j] <= dq_next[j];
                ds_reg[j] <= ds_reg[j-1];
            end

            n1_rem_reg <= n1_rem_next;
            n1_n_reg   <= n1_n_next;
            n1_s_reg   <= ds_reg[DS];
            n2_r_reg   <= R_W'({n2_rem_next, 6'b000000});
            n2_n_reg   <= {n1_n_reg, n2_lo_next};
            n2_s_reg   <= n1_s_reg;

            ta_p_reg[0] <= ta_p_next[0];
            ta_s_reg[0] <= ta_s_next[0];
            ta_r_reg[0] <= n2_r_reg;
            ta_n_reg[0] <= n2_n_reg;
            ta_d_reg[0] <= n2_s_reg;
            for (int k = 1; k < TT; k++)
            begin
                ta_p_reg[k] <= ta_p_next[k];
                ta_s_reg[k] <= ta_s_next[k];
                ta_r_reg[k] <= tb_r_reg[k-1];
                ta_n_reg[k] <= tb_n_reg[k-1];
                ta_d_reg[k] <= tb_d_reg[k-1];
            end
            for (int k = 0; k < TT; k++)
            begin
                tb_p_reg[k] <= tb_p_next[k];
                tb_s_reg[k] <= ta_s_reg[k];
                tb_r_reg[k] <= ta_r_reg[k];
                tb_n_reg[k] <= ta_n_reg[k];
                tb_d_reg[k] <= ta_d_reg[k];
            end

            f1_e_reg <= f1_e_next;
            f1_n_reg <= tb_n_reg[TT-1];
            f1_s_reg <= tb_d_reg[TT-1];

            contribution_reg <= $signed(contribution_next);
        end
    end

    // At the last divider stage the remainder stays below the divisor for live requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[DS] && !ds_reg[DS].zero) |-> (dr_reg[DS] < dd_reg[DS]))
        else $error("divider remainder not below divisor");

    // The ln2 quotient of a value below 32.0 never exceeds 46.
    assert property (@(posedge clk) disable iff (!rst_n)
        (n2_v_reg && !n2_s_reg.zero) |-> (n2_n_reg <= N_W'(46)))
        else $error("range reduction quotient out of bounds");

    // A stalled pipeline keeps the request waiting in the last exp stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (f1_v_reg && !adv) |=> (f1_v_reg && $stable(f1_e_reg)))
        else $error("request lost in exp stage during stall");

    // The weight never exceeds 1.0 in magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((contribution_reg <= $signed(OUT_W'(64'd1 << OUT_FRAC_BITS))) &&
                           (contribution_reg >= -$signed(OUT_W'(64'd1 << OUT_FRAC_BITS)))))
        else $error("weight out of range");

endmodule

`default_nettype wire
